// ===== hdl/hmc_pkg.sv =====
`default_nettype none
package hmc_pkg;

	// Operating modes
	typedef enum logic [1:0] {
		ALWAYS_ON   = 2'd0,
		ALWAYS_OFF  = 2'd1,
		HYST_AUTO   = 2'd2,
		TIMED_CYCLE = 2'd3
	} mode_t;

	// Register indexes on the configuration port
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_MODE        = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HUM_TARGET  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HUM_HYST    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_RUN_MIN = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_WORK_TIME   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_REST_TIME   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_WORK_UNIT   = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_REST_UNIT   = 3'd7;

	// Time scaling
	localparam int unsigned MS_PER_SEC  = 1000;
	localparam int unsigned SEC_PER_MIN = 60;
	localparam int unsigned MS_PER_MIN  = MS_PER_SEC * SEC_PER_MIN;

	// 255 minutes in ms fits in 24 bits
	localparam int unsigned LIM_W = 24;

	// Over-temperature trip point, tenths of a degree
	localparam logic signed [15:0] SAFETY_TEMP_MAX = 16'sd350;

endpackage
`default_nettype wire

// ===== hdl/humidifier_mode_controller.sv =====
`default_nettype none
// Humidifier mode controller. Each input beat is one control poll (millisecond
// timestamp, humidity with error flag, temperature with valid flag); each poll
// yields exactly one result beat with the new drive level and a changed flag.
// The block takes one poll per cycle while the output side keeps taking
// results: a poll is held in the input register, the decision logic (a 32-bit
// time subtract and compare against a limit scaled by a constant) works on it
// there, and the result lands in the output register. Modes: force on
// (unless the sensor reports an error), force off, auto hysteresis below the
// target with a maximum run time in minutes, and a manual work/rest cycle in
// seconds or minutes. A valid temperature at or above the safety limit forces
// the drive off in every mode. Writing a different value to any cycle setting
// restarts the manual cycle in its work phase. Configure only while no poll is
// in flight; there is no read-back.
module humidifier_mode_controller
	import hmc_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// configuration write port
	input  wire logic                    cfg_we,
	input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,
	// poll channel
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [31:0]             now_ms,
	input  wire logic signed [15:0]      humidity,
	input  wire logic                    hum_error,
	input  wire logic signed [15:0]      temperature,
	input  wire logic                    temp_valid,
	// result channel
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic                         hum_out,
	output logic                         out_changed
);

	// Configuration registers
	mode_t              mode_q;
	logic signed [15:0] hum_target_q;
	logic [14:0]        hum_hyst_q;
	logic [7:0]         max_run_min_q;
	logic [7:0]         work_time_q;
	logic [7:0]         rest_time_q;
	logic               work_unit_q;
	logic               rest_unit_q;

	// Controller state
	logic        drive_q;
	logic        phase_q;
	logic [31:0] cycle_start_q;
	logic [31:0] run_start_q;
	logic        restart_q;

	// Input stage
	logic               valid_s1;
	logic [31:0]        now_ms_s1;
	logic signed [15:0] humidity_s1;
	logic               hum_error_s1;
	logic signed [15:0] temperature_s1;
	logic               temp_valid_s1;

	// Output register
	logic out_valid_q;
	logic hum_out_q;
	logic out_changed_q;

	logic in_accept;
	logic advance;

	// Move the staged poll forward when the result slot is free or being drained.
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign in_accept = in_valid && in_ready;

	assign out_valid   = out_valid_q;
	assign hum_out     = hum_out_q;
	assign out_changed = out_changed_q;

	// Configuration writes
	logic cycle_cfg_change;

	always_comb begin
		cycle_cfg_change = 1'b0;
		if (cfg_we) begin
			case (cfg_index)
				REG_WORK_TIME: cycle_cfg_change = (cfg_data[7:0] != work_time_q);
				REG_REST_TIME: cycle_cfg_change = (cfg_data[7:0] != rest_time_q);
				REG_WORK_UNIT: cycle_cfg_change = (cfg_data[0] != work_unit_q);
				REG_REST_UNIT: cycle_cfg_change = (cfg_data[0] != rest_unit_q);
				default:       cycle_cfg_change = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= ALWAYS_OFF;
			hum_target_q  <= '0;
			hum_hyst_q    <= '0;
			max_run_min_q <= '0;
			work_time_q   <= '0;
			rest_time_q   <= '0;
			work_unit_q   <= 1'b0;
			rest_unit_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:        mode_q        <= mode_t'(cfg_data[1:0]);
				REG_HUM_TARGET:  hum_target_q  <= $signed(cfg_data[15:0]);
				REG_HUM_HYST:    hum_hyst_q    <= cfg_data[14:0];
				REG_MAX_RUN_MIN: max_run_min_q <= cfg_data[7:0];
				REG_WORK_TIME:   work_time_q   <= cfg_data[7:0];
				REG_REST_TIME:   rest_time_q   <= cfg_data[7:0];
				REG_WORK_UNIT:   work_unit_q   <= cfg_data[0];
				REG_REST_UNIT:   rest_unit_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input stage: hold the poll until it moves to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			now_ms_s1      <= now_ms;
			humidity_s1    <= humidity;
			hum_error_s1   <= hum_error;
			temperature_s1 <= temperature;
			temp_valid_s1  <= temp_valid;
		end
	end

	// Limits in ms. Comparing the elapsed ms against limit * 1000 is the same as
	// comparing the elapsed whole seconds against the limit in seconds.
	logic [LIM_W-1:0] run_lim_ms;
	logic [LIM_W-1:0] work_lim_ms;
	logic [LIM_W-1:0] rest_lim_ms;

	assign run_lim_ms  = LIM_W'(max_run_min_q) * LIM_W'(MS_PER_MIN);
	assign work_lim_ms = LIM_W'(work_time_q) *
		(work_unit_q ? LIM_W'(MS_PER_MIN) : LIM_W'(MS_PER_SEC));
	assign rest_lim_ms = LIM_W'(rest_time_q) *
		(rest_unit_q ? LIM_W'(MS_PER_MIN) : LIM_W'(MS_PER_SEC));

	// Auto mode compares; the threshold is one bit wider so it never wraps.
	logic signed [16:0] thr;
	logic               hum_below_band;
	logic               hum_at_target;
	logic [31:0]        run_elapsed;
	logic               run_over;

	assign thr = $signed({hum_target_q[15], hum_target_q}) - $signed({2'b00, hum_hyst_q});
	assign hum_below_band = $signed({humidity_s1[15], humidity_s1}) < thr;
	assign hum_at_target  = humidity_s1 >= hum_target_q;
	assign run_elapsed    = now_ms_s1 - run_start_q;
	assign run_over       = run_elapsed >= {{(32-LIM_W){1'b0}}, run_lim_ms};

	// Manual cycle: a pending restart puts the cycle at the start of work.
	logic        phase_eff;
	logic [31:0] start_eff;
	logic [31:0] cyc_elapsed;
	logic [LIM_W-1:0] cyc_lim;
	logic        cyc_over;

	assign phase_eff   = restart_q ? 1'b1 : phase_q;
	assign start_eff   = restart_q ? now_ms_s1 : cycle_start_q;
	assign cyc_elapsed = now_ms_s1 - start_eff;
	assign cyc_lim     = phase_eff ? work_lim_ms : rest_lim_ms;
	assign cyc_over    = cyc_elapsed >= {{(32-LIM_W){1'b0}}, cyc_lim};

	logic safety_trip;

	assign safety_trip = (SAFETY_TEMP_MAX > 16'sd0) && temp_valid_s1 &&
		(temperature_s1 >= SAFETY_TEMP_MAX);

	// Decision and next state for the staged poll
	logic        want;
	logic [31:0] run_start_d;
	logic        phase_d;
	logic [31:0] cycle_start_d;
	logic        restart_clr;

	always_comb begin
		want          = 1'b0;
		run_start_d   = run_start_q;
		phase_d       = phase_q;
		cycle_start_d = cycle_start_q;
		restart_clr   = 1'b0;
		case (mode_q)
			ALWAYS_ON: begin
				want = !hum_error_s1;
			end
			HYST_AUTO: begin
				if (!hum_error_s1) begin
					if (hum_below_band) begin
						want = 1'b1;
					end else if (hum_at_target) begin
						want = 1'b0;
					end else begin
						want = drive_q;
					end
					// cut the drive once it has run too long
					if (want && drive_q && run_over) begin
						want = 1'b0;
					end
					// restart the run timer on switch-on
					if (want && !drive_q) begin
						run_start_d = now_ms_s1;
					end
				end
			end
			TIMED_CYCLE: begin
				// sensor error: drive off, cycle state held
				if (!hum_error_s1) begin
					restart_clr = restart_q;
					if (cyc_over) begin
						phase_d       = !phase_eff;
						cycle_start_d = now_ms_s1;
					end else begin
						phase_d       = phase_eff;
						cycle_start_d = start_eff;
					end
					want = phase_d;
				end
			end
			default: begin
				want = 1'b0;
			end
		endcase
		if (safety_trip) begin
			want = 1'b0;
		end
	end

	// State update, one poll per advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q       <= 1'b0;
			phase_q       <= 1'b0;
			cycle_start_q <= '0;
			run_start_q   <= '0;
		end else if (advance) begin
			drive_q       <= want;
			phase_q       <= phase_d;
			cycle_start_q <= cycle_start_d;
			run_start_q   <= run_start_d;
		end
	end

	// A changed cycle setting wins over the clear from a poll.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_q <= 1'b1;
		end else if (cycle_cfg_change) begin
			restart_q <= 1'b1;
		end else if (advance && restart_clr) begin
			restart_q <= 1'b0;
		end
	end

	// Result register: load on advance, drop when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hum_out_q     <= want;
			out_changed_q <= want ^ drive_q;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/hmc_checker.sv =====
`default_nettype none
module hmc_checker (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic                   hum_out,
	input wire logic                   out_changed
);

	logic       in_beat;
	logic       out_beat;
	logic [1:0] pending_q;
	logic       last_drive_q;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// Track polls in flight and the last delivered drive level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= '0;
			last_drive_q <= 1'b0;
		end else begin
			pending_q <= pending_q + 2'(in_beat) - 2'(out_beat);
			if (out_beat) begin
				last_drive_q <= hum_out;
			end
		end
	end

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hum_out) && $stable(out_changed))
		else $error("result beat changed while stalled");

	// Every result answers a poll, and at most two polls are in flight.
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0 && pending_q <= 2'd2)
		else $error("result beat without a pending poll");

	// With nothing in flight a poll is always taken.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 2'd0 |-> in_ready)
		else $error("input stalled with nothing in flight");

	// The changed flag agrees with the previous delivered level.
	a_changed: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> out_changed == (hum_out ^ last_drive_q))
		else $error("changed flag does not match drive history");

endmodule

bind humidifier_mode_controller hmc_checker u_hmc_checker (.*);
`default_nettype wire

// ===== tb/sv/humidifier_mode_controller_test.sv =====
`timescale 1ns / 100ps

module humidifier_mode_controller_test
	import hmc_pkg::*;
();

	// Watchdog limit for a hung run
	localparam int unsigned CYCLE_LIMIT = 200000;
	// Length of the long output stall that backs the block up
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned RANDOM_PHASES = 12;
	localparam int unsigned POLLS_PER_PHASE = 36;

	// One control poll as seen on the input channel
	typedef struct packed {
		logic [31:0]        now;
		logic signed [15:0] hum;
		logic               err;
		logic signed [15:0] temp;
		logic               tval;
	} poll_t;

	// One result beat: drive level and changed flag
	typedef struct packed {
		logic on;
		logic chg;
	} drive_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [31:0] now_ms;
	logic signed [15:0] humidity;
	logic hum_error;
	logic signed [15:0] temperature;
	logic temp_valid;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hum_out;
	logic out_changed;

	// Shadow copy of the controller: registers
	mode_t m_mode;
	logic signed [15:0] m_target;
	logic [14:0] m_hyst;
	logic [7:0] m_max_run;
	logic [7:0] m_work;
	logic [7:0] m_rest;
	logic m_work_min;
	logic m_rest_min;
	// Shadow copy of the controller: state
	logic m_drive;
	logic m_phase;
	logic m_restart;
	logic [31:0] m_cycle_t0;
	logic [31:0] m_run_t0;

	// Drive levels still owed by the block, oldest first
	drive_t expected_drive[$];
	drive_t want_drive;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;

	// Stimulus control
	logic [31:0] t_ms;
	int unsigned t_step;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	bit rx_hold;
	bit hold_req = 1'b0;
	int unsigned rx_stall = 0;

	humidifier_mode_controller u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.now_ms      (now_ms),
		.humidity    (humidity),
		.hum_error   (hum_error),
		.temperature (temperature),
		.temp_valid  (temp_valid),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hum_out     (hum_out),
		.out_changed (out_changed)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Work out the drive level for one accepted poll and advance the shadow state.
	function automatic drive_t predict_drive(poll_t p);
		logic want;
		logic prev;
		int thr;
		logic [31:0] secs;
		logic [31:0] lim;
		prev = m_drive;
		want = 1'b0;
		case (m_mode)
			ALWAYS_ON: want = !p.err;
			HYST_AUTO: begin
				if (!p.err) begin
					// threshold is exact: a wide band may reach below -32768
					thr = int'(m_target) - int'(m_hyst);
					if (int'($signed(p.hum)) < thr)
						want = 1'b1;
					else if ($signed(p.hum) >= m_target)
						want = 1'b0;
					else
						want = m_drive;
					// cut a run that has lasted its allowed minutes (mod 2^32 time)
					secs = (p.now - m_run_t0) / 32'd1000;
					if (want && m_drive && secs >= 32'(m_max_run) * 32'd60)
						want = 1'b0;
					if (want && !m_drive)
						m_run_t0 = p.now;
				end
			end
			TIMED_CYCLE: begin
				// a sensor error holds the cycle where it is
				if (!p.err) begin
					if (m_restart) begin
						m_restart = 1'b0;
						m_phase = 1'b1;
						m_cycle_t0 = p.now;
					end
					secs = (p.now - m_cycle_t0) / 32'd1000;
					if (m_phase)
						lim = m_work_min ? 32'(m_work) * 32'd60 : 32'(m_work);
					else
						lim = m_rest_min ? 32'(m_rest) * 32'd60 : 32'(m_rest);
					if (secs >= lim) begin
						m_phase = !m_phase;
						m_cycle_t0 = p.now;
					end
					want = m_phase;
				end
			end
			default: want = 1'b0;
		endcase
		// over-temperature trip wins in every mode
		if (p.tval && $signed(p.temp) >= SAFETY_TEMP_MAX)
			want = 1'b0;
		m_drive = want;
		return '{on: want, chg: want != prev};
	endfunction

	// Drop valid and let every owed result come back, plus the pipe latency.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_drive.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write one register while the block is idle and mirror it in the shadow copy.
	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MODE:        m_mode = mode_t'(data[1:0]);
			REG_HUM_TARGET:  m_target = data;
			REG_HUM_HYST:    m_hyst = data[14:0];
			REG_MAX_RUN_MIN: m_max_run = data[7:0];
			// only a real change of a cycle setting restarts the cycle
			REG_WORK_TIME: if (m_work != data[7:0]) begin
				m_work = data[7:0];
				m_restart = 1'b1;
			end
			REG_REST_TIME: if (m_rest != data[7:0]) begin
				m_rest = data[7:0];
				m_restart = 1'b1;
			end
			REG_WORK_UNIT: if (m_work_min != data[0]) begin
				m_work_min = data[0];
				m_restart = 1'b1;
			end
			REG_REST_UNIT: if (m_rest_min != data[0]) begin
				m_rest_min = data[0];
				m_restart = 1'b1;
			end
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Offer one poll after a random gap; log its expected drive once it is taken.
	task automatic send_poll(logic [31:0] now, logic signed [15:0] hum, logic err,
			logic signed [15:0] temp, logic tval);
		int unsigned gap;
		poll_t p;
		gap = tx_burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		now_ms <= now;
		humidity <= hum;
		hum_error <= err;
		temperature <= temp;
		temp_valid <= tval;
		do
			@(posedge clk);
		while (!in_ready);
		p = '{now, hum, err, temp, tval};
		expected_drive.push_back(predict_drive(p));
	endtask

	// Result side: random stall per beat, held low while a long hold-off runs.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_drive.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: hum_out=%0b out_changed=%0b",
							hum_out, out_changed);
				end else begin
					want_drive = expected_drive.pop_front();
					if (hum_out !== want_drive.on || out_changed !== want_drive.chg) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result mismatch at %0t: hum_out exp %0b got %0b,",
								$realtime, want_drive.on, hum_out,
								" out_changed exp %0b got %0b",
								want_drive.chg, out_changed);
					end
				end
				rx_stall = rx_burst ? 0 : $urandom_range(0, 13);
			end else if (rx_stall > 0) begin
				rx_stall--;
			end
			out_ready <= (rx_stall == 0) && !rx_hold;
		end
	end

	// Long hold-off on the result side, counted here so the sender keeps going.
	initial begin
		rx_hold = 1'b0;
		forever begin
			wait (hold_req);
			@(posedge clk);
			rx_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			rx_hold <= 1'b0;
			hold_req = 1'b0;
		end
	end

	// Next poll time: mostly steps on the scale of the current timers, some wild jumps.
	function automatic logic [31:0] advance_time();
		case ($urandom_range(0, 15))
			0:       return t_ms;
			1:       return $urandom;
			2, 3:    return t_ms + $urandom_range(0, 4 * t_step);
			default: return t_ms + $urandom_range(1, t_step);
		endcase
	endfunction

	// Humidity mostly around the switching band, clamped to the field.
	function automatic logic [15:0] pick_humidity();
		int lo;
		int v;
		lo = int'(m_target) - int'(m_hyst);
		case ($urandom_range(0, 9))
			7:       return 16'($urandom);
			8:       v = int'(m_target);
			9:       v = lo - int'($urandom_range(0, 1));
			default: v = lo - 8 + int'($urandom_range(0, int'(m_hyst) + 16));
		endcase
		if (v < -32768)
			v = -32768;
		if (v > 32767)
			v = 32767;
		return 16'(v);
	endfunction

	// Temperature mostly normal, with the trip point and its neighbor hit often.
	function automatic logic [15:0] pick_temp();
		case ($urandom_range(0, 15))
			0:       return SAFETY_TEMP_MAX;
			1:       return SAFETY_TEMP_MAX - 16'sd1;
			2:       return 16'($urandom);
			3:       return 16'(int'(SAFETY_TEMP_MAX) + int'($urandom_range(1, 1150)));
			default: return 16'(int'($urandom_range(0, 749)) - 400);
		endcase
	endfunction

	function automatic logic [7:0] pick_byte_time();
		case ($urandom_range(0, 5))
			0:       return 8'd0;
			1:       return 8'd255;
			5:       return 8'($urandom);
			default: return 8'($urandom_range(1, 4));
		endcase
	endfunction

	// Pick a setting; junk in the unused upper data bits must be ignored.
	task automatic random_setup(bit all_regs);
		int unsigned r;
		int unsigned wsec;
		int unsigned rsec;
		mode_t md;
		logic [15:0] junk;
		logic [15:0] v;
		junk = 16'($urandom);
		r = $urandom_range(0, 9);
		md = (r == 0) ? ALWAYS_ON : (r == 1) ? ALWAYS_OFF :
			(r < 6) ? HYST_AUTO : TIMED_CYCLE;
		if (all_regs || $urandom_range(0, 1)) begin
			case ($urandom_range(0, 4))
				0:       v = 16'h8000;
				1:       v = 16'h7fff;
				2, 3:    v = 16'(int'($urandom_range(0, 4000)) - 2000);
				default: v = 16'($urandom);
			endcase
			write_reg(REG_HUM_TARGET, v);
		end
		if (all_regs || $urandom_range(0, 1)) begin
			case ($urandom_range(0, 4))
				0:       v = 16'h0000;
				1:       v = 16'h7fff;
				2, 3:    v = 16'($urandom_range(0, 200));
				default: v = 16'($urandom);
			endcase
			write_reg(REG_HUM_HYST, {junk[0], v[14:0]});
		end
		if (all_regs || $urandom_range(0, 1))
			write_reg(REG_MAX_RUN_MIN, {junk[15:8], pick_byte_time()});
		if (all_regs || $urandom_range(0, 1))
			write_reg(REG_WORK_TIME, {junk[7:0], pick_byte_time()});
		if (all_regs || $urandom_range(0, 1))
			write_reg(REG_REST_TIME, {junk[12:5], pick_byte_time()});
		if (all_regs || $urandom_range(0, 2) == 0)
			write_reg(REG_WORK_UNIT, {junk[15:1], 1'($urandom_range(0, 3) == 0)});
		if (all_regs || $urandom_range(0, 2) == 0)
			write_reg(REG_REST_UNIT, {junk[14:0], 1'($urandom_range(0, 3) == 0)});
		// rewrite a cycle setting unchanged: must not restart the cycle
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_WORK_TIME, {junk[11:4], m_work});
		write_reg(REG_MODE, {junk[15:2], md});
		// scale the time steps to the timers in play
		wsec = m_work_min ? int'(m_work) * 60 : int'(m_work);
		rsec = m_rest_min ? int'(m_rest) * 60 : int'(m_rest);
		case (m_mode)
			HYST_AUTO:   t_step = (m_max_run == 0) ? 1500 : int'(m_max_run) * 15000;
			TIMED_CYCLE: t_step = (wsec + rsec) * 1000 / 3 + 300;
			default:     t_step = 3000;
		endcase
		// start some phases just short of the counter wrap
		if ($urandom_range(0, 3) == 0)
			t_ms = 32'hffff_ffff - $urandom_range(0, 2 * t_step);
	endtask

	task automatic send_random_poll();
		t_ms = advance_time();
		send_poll(t_ms, pick_humidity(), $urandom_range(0, 11) == 0, pick_temp(),
			$urandom_range(0, 3) != 0);
	endtask

	// Out of reset the block is in force-off with all registers cleared.
	task automatic test_power_on_defaults();
		send_poll(32'd0, 16'sh8000, 1'b1, 16'sh7fff, 1'b0);
		send_poll(32'hffff_ffff, 16'sh7fff, 1'b0, 16'sh8000, 1'b1);
	endtask

	// Force-on follows the error flag; trip point and temp_valid gate it.
	task automatic test_force_modes();
		write_reg(REG_MODE, 16'(ALWAYS_ON));
		send_poll(32'd100, 16'sd0, 1'b0, 16'sd0, 1'b0);
		send_poll(32'd200, 16'sd0, 1'b1, 16'sd0, 1'b0);
		send_poll(32'd300, 16'sd0, 1'b0, SAFETY_TEMP_MAX, 1'b1);
		send_poll(32'd400, 16'sd0, 1'b0, SAFETY_TEMP_MAX - 16'sd1, 1'b1);
		send_poll(32'd500, 16'sd0, 1'b0, SAFETY_TEMP_MAX, 1'b0);
	endtask

	// Hysteresis band edges, max run cut, run timer across the wrap,
	// threshold below the field range, and toggling with a zero max run.
	task automatic test_auto_hysteresis();
		write_reg(REG_HUM_TARGET, 16'd100);
		write_reg(REG_HUM_HYST, 16'd20);
		write_reg(REG_MAX_RUN_MIN, 16'd1);
		write_reg(REG_MODE, 16'(HYST_AUTO));
		send_poll(32'd1000, 16'sd79, 1'b0, 16'sd0, 1'b0);
		send_poll(32'd3000, 16'sd100, 1'b0, 16'sd0, 1'b0);
		send_poll(32'd4000, 16'sd80, 1'b0, 16'sd0, 1'b0);
		send_poll(32'd5000, 16'sd79, 1'b0, 16'sd0, 1'b0);
		send_poll(32'd65000, 16'sd50, 1'b0, 16'sd0, 1'b0);
		send_poll(32'd66000, 16'sd79, 1'b1, 16'sd0, 1'b0);
		send_poll(32'hffff_fc18, 16'sd0, 1'b0, 16'sd0, 1'b0);
		send_poll(32'd58999, 16'sd0, 1'b0, 16'sd0, 1'b0);
		send_poll(32'd59000, 16'sd0, 1'b0, 16'sd0, 1'b0);
		write_reg(REG_HUM_TARGET, 16'h8000);
		write_reg(REG_HUM_HYST, 16'h7fff);
		send_poll(32'd60000, 16'sh8000, 1'b0, 16'sd0, 1'b0);
		write_reg(REG_HUM_TARGET, 16'd0);
		write_reg(REG_HUM_HYST, 16'd0);
		write_reg(REG_MAX_RUN_MIN, 16'd0);
		send_poll(32'd1, -16'sd1, 1'b0, 16'sd0, 1'b0);
		send_poll(32'd2, -16'sd1, 1'b0, 16'sd0, 1'b0);
		send_poll(32'd3, -16'sd1, 1'b0, 16'sd0, 1'b0);
	endtask

	// Work/rest in seconds, then a zero work time after a setting change.
	task automatic test_manual_cycle();
		write_reg(REG_REST_TIME, 16'd1);
		write_reg(REG_WORK_TIME, 16'd2);
		write_reg(REG_MODE, 16'(TIMED_CYCLE));
		send_poll(32'd0, 16'sd0, 1'b0, 16'sd0, 1'b0);
		send_poll(32'd2000, 16'sd0, 1'b0, 16'sd0, 1'b0);
		send_poll(32'd3000, 16'sd0, 1'b0, 16'sd0, 1'b0);
		write_reg(REG_WORK_TIME, 16'd0);
		send_poll(32'd10, 16'sd0, 1'b0, 16'sd0, 1'b0);
		send_poll(32'd1010, 16'sd0, 1'b0, 16'sd0, 1'b0);
	endtask

	// Random settings per phase, random polls with bursts and idle spells.
	task automatic test_random_polls();
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			random_setup(ph == 0);
			for (int n = 0; n < POLLS_PER_PHASE; n++) begin
				if (n % 12 == 0) begin
					tx_burst = ($urandom_range(0, 2) == 0);
					rx_burst <= ($urandom_range(0, 2) == 0);
				end
				send_random_poll();
			end
		end
		tx_burst = 1'b0;
		rx_burst <= 1'b0;
	endtask

	// Stall the result side for a long stretch while polls keep coming.
	task automatic test_output_backpressure();
		random_setup(1'b0);
		hold_req = 1'b1;
		tx_burst = 1'b1;
		for (int n = 0; n < 24; n++)
			send_random_poll();
		tx_burst = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		now_ms = '0;
		humidity = '0;
		hum_error = 1'b0;
		temperature = '0;
		temp_valid = 1'b0;
		// shadow copy starts from the reset state
		m_mode = ALWAYS_OFF;
		m_target = '0;
		m_hyst = '0;
		m_max_run = '0;
		m_work = '0;
		m_rest = '0;
		m_work_min = 1'b0;
		m_rest_min = 1'b0;
		m_drive = 1'b0;
		m_phase = 1'b0;
		m_restart = 1'b1;
		m_cycle_t0 = '0;
		m_run_t0 = '0;
		t_ms = '0;
		t_step = 3000;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_on_defaults();
		test_force_modes();
		test_auto_hysteresis();
		test_manual_cycle();
		test_random_polls();
		test_output_backpressure();

		// drain, then give the pipe time to show any stray beat
		in_valid <= 1'b0;
		while (expected_drive.size() != 0 || hold_req)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/hmc_pkg.sv
hdl/humidifier_mode_controller.sv
hdl/hmc_checker.sv
tb/sv/humidifier_mode_controller_test.sv
